// ----- hdl/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon ray casting unit.
// Used by the command queue, the edge walking engine and the top level.
// No dependencies.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VADDR_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int MIN_VERTICES = 3;

  localparam int COORD_W = 16;
  localparam int IDX_W = 6;
  localparam int VCOUNT_W = 7;

  // Stream word layout.
  localparam int TD_X_LSB = IDX_W;
  localparam int TD_Y_LSB = IDX_W + COORD_W;
  localparam int S_TDATA_W = ((IDX_W + 2 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = 8;

  // Configuration channel.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X = 2'd1;
  localparam logic signed [COORD_W-1:0] RAY_END_RESET = 16'sd10000;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                     op;
    logic [VADDR_W-1:0]          addr;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
  } cmd_t;

endpackage

// ----- hdl/pip_front.sv -----
// Input side of the point-in-polygon unit: unpacks stream words, drops vertex
// writes to slots outside the table and queues commands for the engine.
// Depends on pip_pkg.
module pip_front import pip_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // vertex_index, coord_x, coord_y
  input  logic [0:0]           s_axis_tuser,  // kind
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_t                 cmd
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  cmd_t               queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  logic [IDX_W-1:0]   in_idx;
  cmd_t               in_cmd;
  logic               in_drop;
  logic               enq;
  logic               deq;

  always_comb begin
    in_idx = s_axis_tdata[IDX_W-1:0];
    in_cmd.op = s_axis_tuser[0] ? CMD_QUERY : CMD_VERTEX;
    in_cmd.addr = VADDR_W'(in_idx);
    in_cmd.x = s_axis_tdata[TD_X_LSB +: COORD_W];
    in_cmd.y = s_axis_tdata[TD_Y_LSB +: COORD_W];
    // A vertex write beyond the table has no effect at all.
    in_drop = (in_cmd.op == CMD_VERTEX) && (int'(in_idx) >= MAX_VERTICES);
  end

  assign s_axis_tready = (count != (QPTR_W + 1)'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = queue[rd_ptr];
  assign enq = s_axis_tvalid && s_axis_tready && !in_drop;
  assign deq = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        count <= count + 1'b1;
      end else if (deq && !enq) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

endmodule

// ----- hdl/pip_engine.sv -----
// Edge walking engine: holds the vertex table, runs the crossing test over
// one edge per cycle in a four stage pipeline and keeps the result register.
// Depends on pip_pkg.
module pip_engine import pip_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  cmd_t                       cmd,
  input  logic [VCOUNT_W-1:0]        vertex_count,
  input  logic signed [COORD_W-1:0]  ray_end_x,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata   // inside_res
);

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TURN_W = PROD_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef enum logic [1:0] {
    TURN_COL = 2'd0,
    TURN_CW  = 2'd1,
    TURN_CCW = 2'd2
  } turn_t;

  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // True when q lies within the bounding box of a and c.
  function automatic logic inbox(
    input logic signed [COORD_W-1:0] ax,
    input logic signed [COORD_W-1:0] ay,
    input logic signed [COORD_W-1:0] qx,
    input logic signed [COORD_W-1:0] qy,
    input logic signed [COORD_W-1:0] cx,
    input logic signed [COORD_W-1:0] cy
  );
    return (qx <= ax || qx <= cx) && (qx >= ax || qx >= cx) &&
           (qy <= ay || qy <= cy) && (qy >= ay || qy >= cy);
  endfunction

  function automatic turn_t turn_of(input logic signed [TURN_W-1:0] v);
    if (v == '0) begin
      return TURN_COL;
    end
    return v[TURN_W-1] ? TURN_CCW : TURN_CW;
  endfunction

  // Orientation of the horizontal ray (p to e) against a vertex at height qy.
  // The cross product reduces to -(ex - px) * (qy - py), so signs suffice.
  function automatic turn_t turn_ray(
    input logic signed [COORD_W-1:0] ex,
    input logic signed [COORD_W-1:0] px,
    input logic signed [COORD_W-1:0] qy,
    input logic signed [COORD_W-1:0] py
  );
    if (ex == px || qy == py) begin
      return TURN_COL;
    end
    return ((ex < px) != (qy < py)) ? TURN_CW : TURN_CCW;
  endfunction

  state_t                    state;
  logic [VCNT_W-1:0]         k;
  logic [VCNT_W-1:0]         n;
  logic [VCNT_W-1:0]         n_sat;
  logic                      few;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] ex;
  logic                      parity;
  logic                      decided;
  logic                      dres;
  logic                      out_valid;
  logic                      out_res;
  logic                      out_free;
  logic                      out_load;

  logic [2*COORD_W-1:0]      vmem [MAX_VERTICES];
  logic [2*COORD_W-1:0]      rd_data;
  logic [VADDR_W-1:0]        rd_addr;
  logic                      mem_we;
  logic                      rd_vld;
  logic                      rd_first;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;

  logic                      s1_vld;
  logic signed [DIFF_W-1:0]  s1_byay, s1_pxbx, s1_bxax, s1_pyby, s1_exbx;
  logic signed [DIFF_W-1:0]  s1_pyay, s1_bxpx, s1_pxax, s1_bypy;
  logic                      s1_box1, s1_box2, s1_box3, s1_box4;
  turn_t                     s1_t3, s1_t4;

  logic                      s2_vld;
  logic signed [PROD_W-1:0]  s2_m1, s2_m2, s2_m3, s2_m4, s2_m5;
  logic                      s2_box1, s2_box2, s2_box3, s2_box4;
  turn_t                     s2_t3, s2_t4;

  logic                      s3_vld;
  turn_t                     s3_t1, s3_t2, s3_t3, s3_t4, s3_t5;
  logic                      s3_box1, s3_box2, s3_box3, s3_box4;
  logic                      hit;
  logic                      pipe_empty;

  always_comb begin
    if (int'(vertex_count) > MAX_VERTICES) begin
      n_sat = VCNT_W'(MAX_VERTICES);
    end else begin
      n_sat = VCNT_W'(vertex_count);
    end
  end

  assign few = (n_sat < VCNT_W'(MIN_VERTICES));
  assign out_free = !out_valid || m_axis_tready;
  assign cmd_ready = (state == ST_IDLE) &&
                     (cmd.op == CMD_VERTEX || !few || out_free);
  assign mem_we = cmd_valid && cmd_ready && (cmd.op == CMD_VERTEX);
  // Reads run 0, 1, ..., n-1 and then vertex 0 again to close the polygon.
  assign rd_addr = (k == n) ? '0 : k[VADDR_W-1:0];
  assign pipe_empty = !rd_vld && !s1_vld && !s2_vld && !s3_vld;
  assign cur_x = rd_data[COORD_W-1:0];
  assign cur_y = rd_data[2*COORD_W-1:COORD_W];
  // A result is loaded either at once for a small polygon or after the walk.
  assign out_load = ((state == ST_IDLE) && cmd_valid && cmd_ready &&
                     (cmd.op == CMD_QUERY) && few) ||
                    ((state == ST_DRAIN) && pipe_empty && out_free);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = M_TDATA_W'(out_res);

  assign hit = (s3_t1 != s3_t2 && s3_t3 != s3_t4) ||
               (s3_t1 == TURN_COL && s3_box1) ||
               (s3_t2 == TURN_COL && s3_box2) ||
               (s3_t3 == TURN_COL && s3_box3) ||
               (s3_t4 == TURN_COL && s3_box4);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[cmd.addr] <= {cmd.y, cmd.x};
    end
    rd_data <= vmem[rd_addr];
  end

  // Edge from the previous vertex (a) to the one just read (b).
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    s1_byay <= sub_ext(cur_y, prev_y);
    s1_pxbx <= sub_ext(px, cur_x);
    s1_bxax <= sub_ext(cur_x, prev_x);
    s1_pyby <= sub_ext(py, cur_y);
    s1_exbx <= sub_ext(ex, cur_x);
    s1_pyay <= sub_ext(py, prev_y);
    s1_bxpx <= sub_ext(cur_x, px);
    s1_pxax <= sub_ext(px, prev_x);
    s1_bypy <= sub_ext(cur_y, py);
    s1_box1 <= inbox(prev_x, prev_y, px, py, cur_x, cur_y);
    s1_box2 <= inbox(prev_x, prev_y, ex, py, cur_x, cur_y);
    s1_box3 <= inbox(px, py, prev_x, prev_y, ex, py);
    s1_box4 <= inbox(px, py, cur_x, cur_y, ex, py);
    s1_t3 <= turn_ray(ex, px, prev_y, py);
    s1_t4 <= turn_ray(ex, px, cur_y, py);

    s2_m1 <= s1_byay * s1_pxbx;
    s2_m2 <= s1_bxax * s1_pyby;
    s2_m3 <= s1_byay * s1_exbx;
    s2_m4 <= s1_pyay * s1_bxpx;
    s2_m5 <= s1_pxax * s1_bypy;
    s2_box1 <= s1_box1;
    s2_box2 <= s1_box2;
    s2_box3 <= s1_box3;
    s2_box4 <= s1_box4;
    s2_t3 <= s1_t3;
    s2_t4 <= s1_t4;

    // t1: edge against the query point, t2: against the ray end,
    // t5: query point against the edge, for the on-edge decision.
    s3_t1 <= turn_of(TURN_W'(s2_m1) - TURN_W'(s2_m2));
    s3_t2 <= turn_of(TURN_W'(s2_m3) - TURN_W'(s2_m2));
    s3_t5 <= turn_of(TURN_W'(s2_m4) - TURN_W'(s2_m5));
    s3_box1 <= s2_box1;
    s3_box2 <= s2_box2;
    s3_box3 <= s2_box3;
    s3_box4 <= s2_box4;
    s3_t3 <= s2_t3;
    s3_t4 <= s2_t4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= '0;
      n <= '0;
      parity <= 1'b0;
      decided <= 1'b0;
      out_valid <= 1'b0;
      rd_vld <= 1'b0;
      rd_first <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_WALK);
      rd_first <= (state == ST_WALK) && (k == '0);
      s1_vld <= rd_vld && !rd_first;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // The first intersecting edge that is collinear with the point decides.
      if (s3_vld && hit && !decided) begin
        if (s3_t5 == TURN_COL) begin
          decided <= 1'b1;
          dres <= s3_box1;
        end else begin
          parity <= ~parity;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready && cmd.op == CMD_QUERY) begin
            if (few) begin
              out_res <= 1'b0;
            end else begin
              n <= n_sat;
              px <= cmd.x;
              py <= cmd.y;
              ex <= ray_end_x;
              k <= '0;
              parity <= 1'b0;
              decided <= 1'b0;
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          k <= k + 1'b1;
          if (k == n) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty && out_free) begin
            out_res <= decided ? dres : parity;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/point_in_polygon_ray_cast_unit.sv -----
// Point-in-polygon unit using the ray casting crossing test.
// Input words on the s_axis channel either store one polygon vertex
// (kind 0) or query a point (kind 1). Every query returns one word on the
// m_axis channel whose bit 0 is 1 when the point is inside or on the polygon;
// a vertex write returns nothing. Words leave in the order they came in.
// The cfg channel, always ready, sets vertex_count (index 0) and ray_end_x
// (index 1); users write it only while no query is in flight (unenforced).
// A four word queue decouples the input from the engine, so input words are
// taken while the engine walks a polygon or a result waits on m_axis.
// A vertex write is taken whenever the engine is idle. A query with fewer than three
// vertices answers at once; otherwise the engine reads one vertex per cycle
// from its table port and tests one edge per cycle. The engine takes no new
// word until the walk has drained and the result is loaded, so that memory
// walk sets the query throughput.
// While m_axis is stalled the result is held, the next query still walks its
// edges and then waits for the output register to drain.
// Synchronous reset clears the queue, the engine and the configuration
// (vertex_count 0, ray_end_x 10000); the vertex table keeps stale contents
// and must be rewritten before use.
// Depends on pip_pkg, pip_front and pip_engine.
module point_in_polygon_ray_cast_unit import pip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // vertex_index, coord_x, coord_y
  input  logic [0:0]            s_axis_tuser,   // kind
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // inside_res
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                      cmd_valid;
  logic                      cmd_ready;
  cmd_t                      cmd;
  logic [VCOUNT_W-1:0]       vertex_count;
  logic signed [COORD_W-1:0] ray_end_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      ray_end_x <= RAY_END_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count <= cfg_data[VCOUNT_W-1:0];
        REG_RAY_END_X:    ray_end_x <= cfg_data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pip_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  pip_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .vertex_count  (vertex_count),
    .ray_end_x     (ray_end_x),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef ASSERT_OFF
  // An empty queue always has room for another word.
  a_empty_queue_ready: assert property (@(posedge clk) disable iff (rst)
    !cmd_valid |-> s_axis_tready)
    else $error("input not ready while the command queue is empty");

  // A vertex write never produces a result word.
  a_vertex_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == CMD_VERTEX && !m_axis_tvalid)
      |=> !m_axis_tvalid)
    else $error("result word raised by a vertex write");

  // A query on a polygon of fewer than three vertices answers outside at once.
  a_small_polygon: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && cmd.op == CMD_QUERY &&
     vertex_count < VCOUNT_W'(MIN_VERTICES))
      |=> (m_axis_tvalid && !m_axis_tdata[0]))
    else $error("degenerate polygon query did not answer outside");
`endif

endmodule

// ----- tb/pip_inside_checker.sv -----
// Checker for the point-in-polygon unit: watches the stream and configuration
// words, predicts every query answer with its own ray casting model and
// compares it with the result words. Depends on pip_pkg.
module pip_inside_checker import pip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // vertex_index, coord_x, coord_y
  input  logic [0:0]            s_axis_tuser,   // kind
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [M_TDATA_W-1:0]  m_axis_tdata,   // inside_res
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int MAX_REPORTS = 10;

  typedef enum int {
    TURN_COLLINEAR,
    TURN_CW,
    TURN_CCW
  } turn_t;

  logic signed [COORD_W-1:0] vertex_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] vertex_y [MAX_VERTICES];
  logic [VCOUNT_W-1:0]       vcount;
  logic signed [COORD_W-1:0] ray_x;
  bit                        inside_q [$];
  int                        fail_count = 0;
  int                        wait_count = 0;

  assign mismatches = fail_count;
  assign pending = wait_count;

  function automatic bit in_bbox(input longint ax, ay, qx, qy, cx, cy);
    return qx <= ((ax > cx) ? ax : cx) && qx >= ((ax < cx) ? ax : cx) &&
           qy <= ((ay > cy) ? ay : cy) && qy >= ((ay < cy) ? ay : cy);
  endfunction

  function automatic turn_t orientation(input longint ax, ay, bx, by, cx, cy);
    longint v;
    v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
    if (v == 0) return TURN_COLLINEAR;
    return (v > 0) ? TURN_CW : TURN_CCW;
  endfunction

  // Segment a-b against segment c-d, touching and collinear overlap included.
  function automatic bit edges_intersect(input longint ax, ay, bx, by, cx, cy, dx, dy);
    turn_t t1, t2, t3, t4;
    t1 = orientation(ax, ay, bx, by, cx, cy);
    t2 = orientation(ax, ay, bx, by, dx, dy);
    t3 = orientation(cx, cy, dx, dy, ax, ay);
    t4 = orientation(cx, cy, dx, dy, bx, by);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == TURN_COLLINEAR && in_bbox(ax, ay, cx, cy, bx, by)) return 1'b1;
    if (t2 == TURN_COLLINEAR && in_bbox(ax, ay, dx, dy, bx, by)) return 1'b1;
    if (t3 == TURN_COLLINEAR && in_bbox(cx, cy, ax, ay, dx, dy)) return 1'b1;
    if (t4 == TURN_COLLINEAR && in_bbox(cx, cy, bx, by, dx, dy)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit point_inside(input longint px, py);
    int     n;
    int     j;
    int     crossings;
    longint ex, ax, ay, bx, by;
    n = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
    ex = ray_x;
    crossings = 0;
    if (n < MIN_VERTICES) return 1'b0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      ax = vertex_x[i];
      ay = vertex_y[i];
      bx = vertex_x[j];
      by = vertex_y[j];
      if (edges_intersect(ax, ay, bx, by, px, py, ex, py)) begin
        // A point on the line of a hit edge is decided by that edge alone.
        if (orientation(ax, ay, px, py, bx, by) == TURN_COLLINEAR)
          return in_bbox(ax, ay, px, py, bx, by);
        crossings++;
      end
    end
    return crossings[0];
  endfunction

  always @(posedge clk) begin
    bit                        want;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic [IDX_W-1:0]          slot;
    if (rst) begin
      vcount = '0;
      ray_x = RAY_END_RESET;
      inside_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERTEX_COUNT) vcount = cfg_data[VCOUNT_W-1:0];
        else if (cfg_index == REG_RAY_END_X) ray_x = cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (inside_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("result word %h arrived with no query outstanding", m_axis_tdata);
        end else begin
          want = inside_q.pop_front();
          if (m_axis_tdata[0] !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("inside_res mismatch: expected %0b, got %0b", want, m_axis_tdata[0]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        slot = s_axis_tdata[IDX_W-1:0];
        qx = s_axis_tdata[TD_X_LSB +: COORD_W];
        qy = s_axis_tdata[TD_Y_LSB +: COORD_W];
        if (s_axis_tuser[0] == CMD_QUERY) begin
          inside_q.push_back(point_inside(qx, qy));
        end else begin
          vertex_x[slot] = qx;
          vertex_y[slot] = qy;
        end
      end
    end
    wait_count = inside_q.size();
  end

endmodule

// ----- tb/point_in_polygon_ray_cast_unit_tb.sv -----
// Top of the point-in-polygon unit testbench: clock, reset, polygon and query
// stimulus, result sink and verdict. Checking lives in pip_inside_checker.
// Depends on pip_pkg, pip_inside_checker and point_in_polygon_ray_cast_unit.
module point_in_polygon_ray_cast_unit_tb;
  import pip_pkg::*;

  localparam int MAX_GAP = 9;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 600;
  localparam int TIME_LIMIT = 5_000_000;
  localparam int FULL_SPAN = 0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;   // vertex_index, coord_x, coord_y
  logic [0:0]            s_axis_tuser = '0;   // kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;        // inside_res
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    pending;

  bit burst_mode = 1'b0;
  bit hold_request = 1'b0;
  int items_sent = 0;

  always #5 clk = ~clk;

  point_in_polygon_ray_cast_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pip_inside_checker u_inside_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  function automatic int pick_gap();
    return burst_mode ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input int span);
    int v;
    if (span == FULL_SPAN) begin
      case ($urandom_range(0, 7))
        0: return COORD_MIN;
        1: return COORD_MAX;
        default: return COORD_W'($urandom());
      endcase
    end
    v = int'($urandom_range(0, 2 * span)) - span;
    return COORD_W'(v);
  endfunction

  // Entered and left at a falling edge; valid stays high for a back-to-back word.
  task automatic send_word(input cmd_op_t kind, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    logic [S_TDATA_W-1:0] w;
    int                   gap;
    w = '0;
    w[IDX_W-1:0] = idx;
    w[TD_X_LSB +: COORD_W] = x;
    w[TD_Y_LSB +: COORD_W] = y;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= w;
    s_axis_tuser <= kind;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Vertex writes give no result, so a quiet spell follows the last answer.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(input bit first);
    logic signed [COORD_W-1:0] vx [MAX_VERTICES];
    logic signed [COORD_W-1:0] vy [MAX_VERTICES];
    logic signed [COORD_W-1:0] px, py, ray;
    logic [IDX_W-1:0]          slot;
    int                        n, n_eff, span, queries, r, i, j;
    r = $urandom_range(0, 99);
    if (first) n = $urandom_range(3, 6);
    else if (r < 8) n = $urandom_range(0, 2);
    else if (r < 70) n = $urandom_range(3, 8);
    else if (r < 88) n = $urandom_range(9, 20);
    else if (r < 95) n = MAX_VERTICES;
    else n = $urandom_range(MAX_VERTICES + 1, 127);
    n_eff = (n > MAX_VERTICES) ? MAX_VERTICES : n;
    r = $urandom_range(0, 9);
    span = (r < 5) ? 8 : (r < 8) ? 1000 : FULL_SPAN;
    r = $urandom_range(0, 9);
    if (r < 5) ray = RAY_END_RESET;
    else if (r < 7) ray = rand_coord(span);
    else if (r == 7) ray = COORD_MIN;
    else if (r == 8) ray = COORD_MAX;
    else ray = COORD_W'($urandom());
    burst_mode = ($urandom_range(0, 3) == 0);

    write_reg(REG_VERTEX_COUNT, CFG_DATA_W'(n));
    write_reg(REG_RAY_END_X, ray);
    if ($urandom_range(0, 9) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom()));

    // Every slot the queries will read is loaded first.
    for (i = 0; i < n_eff; i++) begin
      vx[i] = rand_coord(span);
      vy[i] = rand_coord(span);
      send_word(CMD_VERTEX, IDX_W'(i), vx[i], vy[i]);
    end

    if (first) hold_request = 1'b1;
    queries = first ? 24 : $urandom_range(4, 16);
    for (int q = 0; q < queries; q++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        slot = IDX_W'($urandom());
        px = rand_coord(span);
        py = rand_coord(span);
        if (slot < n_eff) begin
          vx[slot] = px;
          vy[slot] = py;
        end
        send_word(CMD_VERTEX, slot, px, py);
      end else begin
        i = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
        j = (i + 1 == n_eff) ? 0 : i + 1;
        if (r < 40 && n_eff > 0) begin
          px = vx[i];
          py = vy[i];
        end else if (r < 55 && n_eff > 0) begin
          px = COORD_W'((longint'(vx[i]) + longint'(vx[j])) / 2);
          py = COORD_W'((longint'(vy[i]) + longint'(vy[j])) / 2);
        end else if (r < 70 && n_eff > 0) begin
          // Same row as a vertex, so the ray grazes it.
          px = rand_coord(span);
          py = vy[i];
        end else begin
          px = rand_coord(span);
          py = rand_coord(span);
        end
        send_word(CMD_QUERY, IDX_W'($urandom()), px, py);
      end
    end
    settle();
  endtask

  // Result sink, with one long hold-off that backs up the input queue.
  initial begin : result_sink
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int random_start;
    bit first_phase;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Nothing in use after reset.
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 0, COORD_MIN, COORD_MAX);
    send_word(CMD_VERTEX, 0, -100, -100);
    send_word(CMD_VERTEX, 1, 100, -100);
    send_word(CMD_VERTEX, 2, 100, 100);
    send_word(CMD_VERTEX, 3, -100, 100);
    send_word(CMD_VERTEX, 63, COORD_MAX, COORD_MIN);
    settle();

    write_reg(REG_VERTEX_COUNT, 2);
    send_word(CMD_QUERY, 0, 0, 0);
    settle();

    // Square: inside, outside, on an edge, on a corner, on the top edge, and
    // on the line of the bottom edge but off its end.
    write_reg(REG_VERTEX_COUNT, 4);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 0, 200, 0);
    send_word(CMD_QUERY, 0, 100, 50);
    send_word(CMD_QUERY, 0, 100, 100);
    send_word(CMD_QUERY, 0, 0, 100);
    send_word(CMD_QUERY, 0, -150, -100);
    settle();

    // Ray end to the left of the query point.
    write_reg(REG_RAY_END_X, COORD_MIN);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 0, -200, 0);
    settle();

    write_reg(REG_RAY_END_X, COORD_MAX);
    send_word(CMD_VERTEX, 0, COORD_MIN, COORD_MIN);
    send_word(CMD_VERTEX, 1, COORD_MAX, COORD_MIN);
    send_word(CMD_VERTEX, 2, COORD_MAX, COORD_MAX);
    send_word(CMD_VERTEX, 3, COORD_MIN, COORD_MAX);
    send_word(CMD_QUERY, 0, 0, 0);
    send_word(CMD_QUERY, 0, COORD_MIN, 0);
    send_word(CMD_QUERY, 0, COORD_MAX, COORD_MAX);
    settle();

    // Writes to unused register indexes must leave the setup alone.
    write_reg(REG_SPARE_A, 16'h0003);
    write_reg(REG_SPARE_B, 16'hFFFF);
    send_word(CMD_QUERY, 63, 5, 5);
    settle();

    random_start = items_sent;
    first_phase = 1'b1;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      random_phase(first_phase);
      first_phase = 1'b0;
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #(TIME_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
